@@ hw/rtl/quorum_transaction_tracker_defines.svh @@
// ----------------------------------------------------------------------------
// quorum_transaction_tracker_defines
// assertion macros shared by the tracker checker
// ----------------------------------------------------------------------------
`ifndef QUORUM_TRANSACTION_TRACKER_DEFINES_SVH
`define QUORUM_TRANSACTION_TRACKER_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define QTT_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define QTT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/qtt_pkg.sv @@
// ----------------------------------------------------------------------------
// qtt_pkg
// types and constants of the quorum transaction tracker
// ----------------------------------------------------------------------------
package qtt_pkg;

   localparam int ID_W        = 16;
   localparam int OP_W        = 2;
   localparam int TICK_W      = 16;
   localparam int CNT_W       = 3;
   localparam int TIMEOUT_W   = 8;
   localparam int MAX_RESULTS = 16;
   localparam int POP_W       = $clog2(MAX_RESULTS);

   localparam logic [CNT_W-1:0]     REPLICAS      = 3'd3;
   localparam logic [CNT_W-1:0]     QUORUM        = 3'd2;
   localparam logic [CNT_W-1:0]     COUNT_MAX     = 3'd7;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 8'd10;
   localparam logic [POP_W-1:0]     LAST_POP      = POP_W'(MAX_RESULTS - 1);

   typedef enum logic [1:0] {
      CMD_OPEN  = 2'd0,
      CMD_REPLY = 2'd1,
      CMD_TICK  = 2'd2
   } qtt_command_type;

   typedef enum logic [1:0] {
      ST_SUCCESS    = 2'd0,
      ST_REPLY_FAIL = 2'd1,
      ST_TIMEOUT    = 2'd2,
      ST_FULL       = 2'd3
   } qtt_status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_SCAN = 1'b1
   } qtt_state_type;

   // controller to datapath
   typedef struct packed {
      logic do_open;
      logic do_reply;
      logic do_tick;
      logic do_pop;
      logic load_reject;
   } qtt_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic id_hit;
      logic table_full;
      logic retire_any;
      logic pop_last;
   } qtt_stat_type;

endpackage

@@ hw/rtl/qtt_req_if.sv @@
// ----------------------------------------------------------------------------
// qtt_req_if
// request channel: open, reply and tick items
// ----------------------------------------------------------------------------
interface qtt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [15:0] trans_id;
   logic [1:0]  op_type;
   logic        reply_ok;

   modport source (output valid, command, trans_id, op_type, reply_ok, input ready);
   modport sink   (input valid, command, trans_id, op_type, reply_ok, output ready);
endinterface

@@ hw/rtl/qtt_rsp_if.sv @@
// ----------------------------------------------------------------------------
// qtt_rsp_if
// response channel: retired or rejected transactions
// ----------------------------------------------------------------------------
interface qtt_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] done_id;
   logic [1:0]  done_op;
   logic [1:0]  status;
   logic        last;

   modport source (output valid, done_id, done_op, status, last, input ready);
   modport sink   (input valid, done_id, done_op, status, last, output ready);
endinterface

@@ hw/rtl/quorum_transaction_tracker.sv @@
// ----------------------------------------------------------------------------
// quorum_transaction_tracker
// table of outstanding three-replica transactions with quorum retirement
// ----------------------------------------------------------------------------
//  channel   direction  handshake        payload
//  req_if    in         valid / ready    command, trans_id, op_type, reply_ok
//  rsp_if    out        valid / ready    done_id, done_op, status, last
//  csr       in         wr_en            wr_data (timeout_ticks)
//
//  the id match of open and reply over the whole table is parallel.
//  a tick snapshots the retire mask; the scan then retires at most 16 entries,
//  stepping through the snapshot retire mask one entry per cycle.
//  results leave through one output register; a held result stalls the scan,
//  and a new item is taken while the last result waits if the register frees.
//  reset is synchronous and clears the table valid bits at once.
// ----------------------------------------------------------------------------
module quorum_transaction_tracker #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   qtt_req_if.sink      req_if,
   qtt_rsp_if.source    rsp_if,
   input  logic         csr_wr_en,
   input  logic [7:0]   csr_wr_data
);
   import qtt_pkg::*;

   qtt_cmd_type  cmd;
   qtt_stat_type stat;

   qtt_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_if.valid),
      .req_command (req_if.command),
      .req_ready   (req_if.ready),
      .rsp_valid   (rsp_if.valid),
      .rsp_ready   (rsp_if.ready),
      .stat        (stat),
      .cmd         (cmd)
   );

   qtt_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .req_trans_id (req_if.trans_id),
      .req_op_type  (req_if.op_type),
      .req_reply_ok (req_if.reply_ok),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .rsp_done_id  (rsp_if.done_id),
      .rsp_done_op  (rsp_if.done_op),
      .rsp_status   (rsp_if.status),
      .rsp_last     (rsp_if.last)
   );

endmodule

@@ hw/rtl/qtt_ctrl.sv @@
// ----------------------------------------------------------------------------
// qtt_ctrl
// controller: accepts items, sequences the retirement scan, owns rsp valid
// ----------------------------------------------------------------------------
module qtt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [1:0]           req_command,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  qtt_pkg::qtt_stat_type stat,
   output qtt_pkg::qtt_cmd_type  cmd
);
   import qtt_pkg::*;

   qtt_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;
   logic          accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      accept    = 1'b0;
      // output register can take a new item this cycle
      out_free  = !rsp_valid_ff || rsp_ready;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = out_free;
            accept    = req_valid && out_free;
            if (accept) begin
               unique case (req_command)
                  CMD_OPEN: begin
                     cmd.do_open     = 1'b1;
                     cmd.load_reject = !stat.id_hit && stat.table_full;
                  end
                  CMD_REPLY: begin
                     cmd.do_reply = 1'b1;
                  end
                  CMD_TICK: begin
                     cmd.do_tick = 1'b1;
                     if (stat.retire_any) begin
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (out_free) begin
               cmd.do_pop = 1'b1;
               if (stat.pop_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (cmd.load_reject || cmd.do_pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ hw/rtl/qtt_datapath.sv @@
// ----------------------------------------------------------------------------
// qtt_datapath
// transaction table, id match, quorum judges, retire mask and output register
// ----------------------------------------------------------------------------
module qtt_datapath #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  qtt_pkg::qtt_cmd_type  cmd,
   output qtt_pkg::qtt_stat_type stat,
   input  logic [15:0]          req_trans_id,
   input  logic [1:0]           req_op_type,
   input  logic                 req_reply_ok,
   input  logic                 csr_wr_en,
   input  logic [7:0]           csr_wr_data,
   output logic [15:0]          rsp_done_id,
   output logic [1:0]           rsp_done_op,
   output logic [1:0]           rsp_status,
   output logic                 rsp_last
);
   import qtt_pkg::*;

   localparam int IDX_W = $clog2(TABLE_DEPTH);

   // table
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic [ID_W-1:0]        id_ff        [TABLE_DEPTH];
   logic [OP_W-1:0]        op_ff        [TABLE_DEPTH];
   logic [TICK_W-1:0]      stamp_ff     [TABLE_DEPTH];
   logic [CNT_W-1:0]       replies_ff   [TABLE_DEPTH];
   logic [CNT_W-1:0]       successes_ff [TABLE_DEPTH];
   logic [CNT_W-1:0]       replies_in   [TABLE_DEPTH];
   logic [CNT_W-1:0]       successes_in [TABLE_DEPTH];

   logic [TICK_W-1:0]      now_ff, now_in;
   logic [TIMEOUT_W-1:0]   timeout_ff, timeout_in;

   // scan state, snapshot taken when a tick is accepted
   logic [TABLE_DEPTH-1:0] mask_ff, mask_in;
   logic [1:0]             judge_st_ff [TABLE_DEPTH];
   logic [POP_W-1:0]       pop_cnt_ff, pop_cnt_in;

   // output register
   logic [ID_W-1:0]        out_id_ff, out_id_in;
   logic [OP_W-1:0]        out_op_ff, out_op_in;
   logic [1:0]             out_st_ff, out_st_in;
   logic                   out_last_ff, out_last_in;

   // lookups
   logic [TABLE_DEPTH-1:0] hit;
   logic [TABLE_DEPTH-1:0] free_oh;
   logic [TABLE_DEPTH-1:0] retire;
   logic [1:0]             judge_st [TABLE_DEPTH];
   logic [TICK_W-1:0]      age      [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] pick;
   logic [IDX_W-1:0]       pick_idx;
   logic                   store_open;
   logic                   id_hit;
   logic                   table_full;
   logic                   retire_any;
   logic                   pop_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         now_ff     <= '0;
         timeout_ff <= TIMEOUT_RESET;
         mask_ff    <= '0;
         pop_cnt_ff <= '0;
      end else begin
         valid_ff   <= valid_in;
         now_ff     <= now_in;
         timeout_ff <= timeout_in;
         mask_ff    <= mask_in;
         pop_cnt_ff <= pop_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (store_open && free_oh[i]) begin
            id_ff[i]    <= req_trans_id;
            op_ff[i]    <= req_op_type;
            stamp_ff[i] <= now_ff;
         end
         replies_ff[i]   <= replies_in[i];
         successes_ff[i] <= successes_in[i];
         if (cmd.do_tick) begin
            judge_st_ff[i] <= judge_st[i];
         end
      end
      out_id_ff   <= out_id_in;
      out_op_ff   <= out_op_in;
      out_st_ff   <= out_st_in;
      out_last_ff <= out_last_in;
   end

   // id match and lowest free slot
   always_comb begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         hit[i] = valid_ff[i] && (id_ff[i] == req_trans_id);
      end
      free_oh    = ~valid_ff & (valid_ff + TABLE_DEPTH'(1));
      id_hit     = |hit;
      table_full = &valid_ff;
      store_open = cmd.do_open && !id_hit && !table_full;
   end

   // quorum rules per entry, in their order of precedence
   always_comb begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         age[i]      = now_ff - stamp_ff[i];
         retire[i]   = valid_ff[i];
         judge_st[i] = ST_SUCCESS;
         priority if (replies_ff[i] == REPLICAS && successes_ff[i] >= QUORUM) begin
            judge_st[i] = ST_SUCCESS;
         end else if (replies_ff[i] != REPLICAS && successes_ff[i] == QUORUM) begin
            judge_st[i] = ST_SUCCESS;
         end else if (replies_ff[i] == REPLICAS) begin
            judge_st[i] = ST_REPLY_FAIL;
         end else if (replies_ff[i] >= successes_ff[i] &&
                      (replies_ff[i] - successes_ff[i]) == QUORUM) begin
            judge_st[i] = ST_REPLY_FAIL;
         end else if (age[i] > TICK_W'(timeout_ff)) begin
            judge_st[i] = ST_TIMEOUT;
         end else begin
            retire[i] = 1'b0;
         end
      end
      retire_any = |retire;
   end

   // next retirement in slot order
   always_comb begin
      pick     = mask_ff & (~mask_ff + TABLE_DEPTH'(1));
      pick_idx = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (pick[i]) begin
            pick_idx = pick_idx | IDX_W'(i);
         end
      end
      pop_last = ((mask_ff & ~pick) == '0) || (pop_cnt_ff == LAST_POP);
   end

   assign stat.id_hit     = id_hit;
   assign stat.table_full = table_full;
   assign stat.retire_any = retire_any;
   assign stat.pop_last   = pop_last;

   always_comb begin
      valid_in    = valid_ff;
      now_in      = now_ff;
      timeout_in  = timeout_ff;
      mask_in     = mask_ff;
      pop_cnt_in  = pop_cnt_ff;
      out_id_in   = out_id_ff;
      out_op_in   = out_op_ff;
      out_st_in   = out_st_ff;
      out_last_in = out_last_ff;

      for (int i = 0; i < TABLE_DEPTH; i++) begin
         replies_in[i]   = replies_ff[i];
         successes_in[i] = successes_ff[i];
         if (store_open && free_oh[i]) begin
            replies_in[i]   = '0;
            successes_in[i] = '0;
         end else if (cmd.do_reply && hit[i]) begin
            if (replies_ff[i] != COUNT_MAX) begin
               replies_in[i] = replies_ff[i] + CNT_W'(1);
            end
            if (req_reply_ok && successes_ff[i] != COUNT_MAX) begin
               successes_in[i] = successes_ff[i] + CNT_W'(1);
            end
         end
      end

      if (csr_wr_en) begin
         timeout_in = csr_wr_data;
      end

      if (store_open) begin
         valid_in = valid_ff | free_oh;
      end

      if (cmd.do_tick) begin
         mask_in    = retire;
         pop_cnt_in = '0;
         now_in     = now_ff + TICK_W'(1);
      end

      if (cmd.load_reject) begin
         out_id_in   = req_trans_id;
         out_op_in   = req_op_type;
         out_st_in   = ST_FULL;
         out_last_in = 1'b1;
      end

      if (cmd.do_pop) begin
         valid_in    = valid_ff & ~pick;
         mask_in     = mask_ff & ~pick;
         pop_cnt_in  = pop_cnt_ff + POP_W'(1);
         out_id_in   = id_ff[pick_idx];
         out_op_in   = op_ff[pick_idx];
         out_st_in   = judge_st_ff[pick_idx];
         out_last_in = pop_last;
      end
   end

   assign rsp_done_id = out_id_ff;
   assign rsp_done_op = out_op_ff;
   assign rsp_status  = out_st_ff;
   assign rsp_last    = out_last_ff;

endmodule

@@ hw/rtl/qtt_checker.sv @@
// ----------------------------------------------------------------------------
// qtt_checker
// port-level checks of the tracker, bound to the top level
// ----------------------------------------------------------------------------
`include "quorum_transaction_tracker_defines.svh"

module qtt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [1:0]  req_command,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_done_id,
   input logic [1:0]  rsp_done_op,
   input logic [1:0]  rsp_status,
   input logic        rsp_last
);
   import qtt_pkg::*;

   logic fresh_full;
   logic rsp_wait_ff;
   logic open_taken_ff;

   // rsp item held and req open taken, as seen at the previous edge
   always_ff @(posedge clock) begin
      rsp_wait_ff   <= rsp_valid && !rsp_ready;
      open_taken_ff <= req_valid && req_ready && (req_command == CMD_OPEN);
   end

   // a table-full result loaded into the output register at this edge
   assign fresh_full = rsp_valid && (rsp_status == ST_FULL) && !rsp_wait_ff;

   `QTT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_done_id) && $stable(rsp_done_op) &&
      $stable(rsp_status) && $stable(rsp_last),
      "rsp item dropped or changed while stalled")

   `QTT_ASSERT_SAME(a_full_is_last, rsp_valid && rsp_status == ST_FULL, rsp_last,
      "table-full item without last")

   `QTT_ASSERT_SAME(a_burst_blocks_req, rsp_valid && !rsp_last, !req_ready,
      "req taken in the middle of a retirement burst")

   `QTT_ASSERT_SAME(a_full_after_open, fresh_full, open_taken_ff,
      "table-full item without an open")

endmodule

bind quorum_transaction_tracker qtt_checker u_qtt_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_if.valid),
   .req_ready   (req_if.ready),
   .req_command (req_if.command),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .rsp_done_id (rsp_if.done_id),
   .rsp_done_op (rsp_if.done_op),
   .rsp_status  (rsp_if.status),
   .rsp_last    (rsp_if.last)
);

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the quorum transaction tracker: a table model
// predicts every retirement and rejection, results are compared in order
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

localparam int TRACKER_SLOTS = 16;

typedef struct packed {
   logic [15:0]                id;
   logic [1:0]                 op;
   qtt_pkg::qtt_status_type    status;
   logic                       last;
} retirement_type;

class retirement_board_type;
   bit          slot_used    [TRACKER_SLOTS];
   logic [15:0] slot_id      [TRACKER_SLOTS];
   logic [1:0]  slot_op      [TRACKER_SLOTS];
   logic [15:0] slot_stamp   [TRACKER_SLOTS];
   logic [2:0]  slot_replies [TRACKER_SLOTS];
   logic [2:0]  slot_oks     [TRACKER_SLOTS];
   logic [15:0] now_tick;
   logic [7:0]  timeout_ticks;
   retirement_type due_q [$];
   int          failures;

   function new();
      now_tick      = '0;
      timeout_ticks = qtt_pkg::TIMEOUT_RESET;
      failures      = 0;
      foreach (slot_used[i]) slot_used[i] = 1'b0;
   endfunction

   function int pending();
      return due_q.size();
   endfunction

   function int find_slot(logic [15:0] id);
      for (int i = 0; i < TRACKER_SLOTS; i++)
         if (slot_used[i] && slot_id[i] == id) return i;
      return -1;
   endfunction

   // status of a retiring entry, or -1 if it stays
   function int verdict(int i);
      logic [2:0]  r;
      logic [2:0]  s;
      logic [15:0] age;
      r   = slot_replies[i];
      s   = slot_oks[i];
      age = now_tick - slot_stamp[i];
      if (r == qtt_pkg::REPLICAS && s >= qtt_pkg::QUORUM) return int'(qtt_pkg::ST_SUCCESS);
      if (r != qtt_pkg::REPLICAS && s == qtt_pkg::QUORUM) return int'(qtt_pkg::ST_SUCCESS);
      if (r == qtt_pkg::REPLICAS && s < qtt_pkg::QUORUM) return int'(qtt_pkg::ST_REPLY_FAIL);
      // enough failed replies that quorum can no longer be reached
      if (r >= s && (r - s) == qtt_pkg::REPLICAS - qtt_pkg::QUORUM + 3'd1)
         return int'(qtt_pkg::ST_REPLY_FAIL);
      if (age > {8'd0, timeout_ticks}) return int'(qtt_pkg::ST_TIMEOUT);
      return -1;
   endfunction

   function void expect_retirement(logic [15:0] id, logic [1:0] op,
                                   qtt_pkg::qtt_status_type status, logic last);
      retirement_type want;
      want.id     = id;
      want.op     = op;
      want.status = status;
      want.last   = last;
      due_q.push_back(want);
   endfunction

   function void take_item(logic [1:0] cmd, logic [15:0] id, logic [1:0] op, logic ok);
      int                      slot;
      int                      code;
      int                      n;
      int                      held_slot;
      qtt_pkg::qtt_status_type held_code;
      case (cmd)
         qtt_pkg::CMD_OPEN: begin
            if (find_slot(id) >= 0) return;
            for (int i = 0; i < TRACKER_SLOTS; i++) begin
               if (!slot_used[i]) begin
                  slot_used[i]    = 1'b1;
                  slot_id[i]      = id;
                  slot_op[i]      = op;
                  slot_stamp[i]   = now_tick;
                  slot_replies[i] = '0;
                  slot_oks[i]     = '0;
                  return;
               end
            end
            expect_retirement(id, op, qtt_pkg::ST_FULL, 1'b1);
         end
         qtt_pkg::CMD_REPLY: begin
            slot = find_slot(id);
            if (slot >= 0) begin
               if (slot_replies[slot] != qtt_pkg::COUNT_MAX) slot_replies[slot]++;
               if (ok && slot_oks[slot] != qtt_pkg::COUNT_MAX) slot_oks[slot]++;
            end
         end
         qtt_pkg::CMD_TICK: begin
            n         = 0;
            held_slot = -1;
            held_code = qtt_pkg::ST_SUCCESS;
            // one retirement is held back so the final one can carry last
            for (int i = 0; i < TRACKER_SLOTS && n < qtt_pkg::MAX_RESULTS; i++) begin
               if (slot_used[i]) begin
                  code = verdict(i);
                  if (code >= 0) begin
                     if (held_slot >= 0)
                        expect_retirement(slot_id[held_slot], slot_op[held_slot],
                                          held_code, 1'b0);
                     held_slot    = i;
                     held_code    = qtt_pkg::qtt_status_type'(code);
                     slot_used[i] = 1'b0;
                     n++;
                  end
               end
            end
            if (held_slot >= 0)
               expect_retirement(slot_id[held_slot], slot_op[held_slot], held_code, 1'b1);
            now_tick++;
         end
         default: begin
         end
      endcase
   endfunction

   function void match_retirement(logic [15:0] id, logic [1:0] op, logic [1:0] status,
                                  logic last);
      retirement_type want;
      if (due_q.size() == 0) begin
         $error("unexpected result: done_id %h done_op %0d status %0d last %0b",
                id, op, status, last);
         failures++;
         return;
      end
      want = due_q.pop_front();
      if (id !== want.id) begin
         $error("done_id: expected %h, actual %h", want.id, id);
         failures++;
      end
      if (op !== want.op) begin
         $error("done_op: expected %0d, actual %0d", want.op, op);
         failures++;
      end
      if (status !== want.status) begin
         $error("status: expected %0d, actual %0d", want.status, status);
         failures++;
      end
      if (last !== want.last) begin
         $error("last: expected %0b, actual %0b", want.last, last);
         failures++;
      end
   endfunction
endclass

module tb;
   import qtt_pkg::*;

   localparam logic [1:0]  CMD_NONE      = 2'd3;
   localparam logic [1:0]  OP_CREATE     = 2'd0;
   localparam logic [1:0]  OP_READ       = 2'd1;
   localparam logic [1:0]  OP_UPDATE     = 2'd2;
   localparam logic [1:0]  OP_DELETE     = 2'd3;
   localparam int          IDLE_PCT      = 13;
   localparam int          HOLD_CYCLES   = 300;
   localparam int          SETTLE_CYCLES = 30;
   localparam int          STALL_LIMIT   = 2000;
   localparam int          ID_MEMORY     = 24;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [7:0]  csr_wr_data;

   qtt_req_if req_bus ();
   qtt_rsp_if rsp_bus ();

   quorum_transaction_tracker #(
      .TABLE_DEPTH (TRACKER_SLOTS)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_bus),
      .rsp_if      (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   retirement_board_type board;
   logic [15:0]     open_ids [$];
   bit              calm;
   bit              hold_off_req;
   bit              hold_taken;
   int              hold_left;
   int              stall_cycles;
   int              items_sent;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // result side: random stalls plus one long hold-off
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
         end
         if (reset) begin
            rsp_bus.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (calm) begin
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         board.match_retirement(rsp_bus.done_id, rsp_bus.done_op, rsp_bus.status,
                                rsp_bus.last);
   end

   initial begin
      stall_cycles = 0;
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            stall_cycles = 0;
         else
            stall_cycles++;
      end
      $display("Verification failed");
      $finish;
   end

   task automatic send_item(logic [1:0] cmd, logic [15:0] id, logic [1:0] op, logic ok);
      int gap;
      gap = 0;
      if (!calm && $urandom_range(0, 99) < IDLE_PCT) gap = $urandom_range(1, 5);
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.command  <= cmd;
      req_bus.trans_id <= id;
      req_bus.op_type  <= op;
      req_bus.reply_ok <= ok;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      board.take_item(cmd, id, op, ok);
      if (cmd != CMD_NONE) items_sent++;
   endtask

   // stop sending and wait until the block has nothing left to report
   task automatic settle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_timeout(logic [7:0] ticks);
      settle();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= ticks;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      board.timeout_ticks = ticks;
   endtask

   function automatic void remember_id(logic [15:0] id);
      open_ids.push_back(id);
      if (open_ids.size() > ID_MEMORY) void'(open_ids.pop_front());
   endfunction

   // mostly ids of recently opened transactions, sometimes a random one
   function automatic logic [15:0] some_id();
      if (open_ids.size() == 0 || $urandom_range(0, 99) < 20) return 16'($urandom);
      return open_ids[$urandom_range(0, open_ids.size() - 1)];
   endfunction

   task automatic run_traffic(int quota);
      int          target;
      int          pick;
      int          replies;
      logic [15:0] id;
      target = items_sent + quota;
      while (items_sent < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            // a whole transaction: open, a few replies, maybe a tick
            id = 16'($urandom);
            remember_id(id);
            send_item(CMD_OPEN, id, 2'($urandom), 1'($urandom));
            replies = $urandom_range(1, 4);
            repeat (replies)
               send_item(CMD_REPLY, id, 2'($urandom), $urandom_range(0, 99) < 65);
            if ($urandom_range(0, 99) < 40)
               send_item(CMD_TICK, 16'($urandom), 2'($urandom), 1'($urandom));
         end else if (pick < 60) begin
            send_item(CMD_REPLY, some_id(), 2'($urandom), 1'($urandom));
         end else if (pick < 80) begin
            send_item(CMD_TICK, 16'($urandom), 2'($urandom), 1'($urandom));
         end else if (pick < 88) begin
            send_item(CMD_OPEN, some_id(), 2'($urandom), 1'($urandom));
         end else if (pick < 93) begin
            send_item(CMD_REPLY, 16'($urandom), 2'($urandom), 1'($urandom));
         end else begin
            send_item(CMD_NONE, 16'($urandom), 2'($urandom), 1'($urandom));
         end
      end
   endtask

   initial begin
      logic [15:0] fill_ids [TRACKER_SLOTS + 2];
      board            = new();
      reset            = 1'b1;
      csr_wr_en        = 1'b0;
      csr_wr_data      = '0;
      req_bus.valid    = 1'b0;
      req_bus.command  = CMD_OPEN;
      req_bus.trans_id = '0;
      req_bus.op_type  = OP_CREATE;
      req_bus.reply_ok = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed, under the reset timeout
      send_item(CMD_OPEN, 16'h0000, OP_CREATE, 1'b0);
      send_item(CMD_OPEN, 16'hFFFF, OP_DELETE, 1'b1);
      send_item(CMD_OPEN, 16'h1234, OP_READ, 1'b0);
      send_item(CMD_OPEN, 16'h1234, OP_UPDATE, 1'b0);   // duplicate id
      send_item(CMD_REPLY, 16'hABCD, OP_CREATE, 1'b1);  // unknown id
      send_item(CMD_REPLY, 16'h0000, OP_CREATE, 1'b1);
      send_item(CMD_REPLY, 16'h0000, OP_CREATE, 1'b1);
      send_item(CMD_REPLY, 16'hFFFF, OP_CREATE, 1'b0);
      send_item(CMD_REPLY, 16'hFFFF, OP_CREATE, 1'b0);
      send_item(CMD_REPLY, 16'h1234, OP_CREATE, 1'b1);
      send_item(CMD_REPLY, 16'h1234, OP_CREATE, 1'b0);
      send_item(CMD_REPLY, 16'h1234, OP_CREATE, 1'b0);
      send_item(CMD_TICK, 16'h0000, OP_CREATE, 1'b0);
      send_item(CMD_NONE, 16'hFFFF, OP_DELETE, 1'b1);
      // counts must stick at their maximum, a wrap would look like two failures
      send_item(CMD_OPEN, 16'h5A5A, OP_UPDATE, 1'b0);
      repeat (8) send_item(CMD_REPLY, 16'h5A5A, OP_CREATE, 1'b1);
      repeat (2) send_item(CMD_REPLY, 16'h5A5A, OP_CREATE, 1'b0);
      send_item(CMD_TICK, 16'hFFFF, OP_DELETE, 1'b1);

      write_timeout(8'd0);
      run_traffic(3);

      // fill the table past full while the result side is held off
      write_timeout(8'd255);
      hold_off_req = 1'b1;
      for (int i = 0; i < TRACKER_SLOTS + 2; i++) begin
         fill_ids[i] = 16'($urandom);
         send_item(CMD_OPEN, fill_ids[i], 2'(i), 1'b0);
      end
      for (int i = 0; i < TRACKER_SLOTS; i++) begin
         case (i % 4)
            0: begin
               send_item(CMD_REPLY, fill_ids[i], OP_CREATE, 1'b1);
               send_item(CMD_REPLY, fill_ids[i], OP_CREATE, 1'b1);
            end
            1: begin
               send_item(CMD_REPLY, fill_ids[i], OP_CREATE, 1'b0);
               send_item(CMD_REPLY, fill_ids[i], OP_CREATE, 1'b0);
            end
            2: begin
               send_item(CMD_REPLY, fill_ids[i], OP_CREATE, 1'b1);
               send_item(CMD_REPLY, fill_ids[i], OP_CREATE, 1'b0);
               send_item(CMD_REPLY, fill_ids[i], OP_CREATE, 1'b0);
            end
            default: send_item(CMD_REPLY, fill_ids[i], OP_CREATE, 1'b1);
         endcase
      end
      send_item(CMD_TICK, 16'h0000, OP_CREATE, 1'b0);
      run_traffic(3);

      write_timeout(8'($urandom_range(1, 254)));
      calm = 1'b1;
      run_traffic(5);

      // empty the table, then walk an entry across the timeout boundary
      write_timeout(8'd0);
      send_item(CMD_TICK, 16'h0000, OP_CREATE, 1'b0);
      send_item(CMD_TICK, 16'h0000, OP_CREATE, 1'b0);
      write_timeout(8'd3);
      send_item(CMD_OPEN, 16'($urandom), 2'($urandom), 1'b0);
      repeat (3) send_item(CMD_TICK, 16'h0000, OP_CREATE, 1'b0);
      send_item(CMD_OPEN, 16'($urandom), 2'($urandom), 1'b0);
      repeat (6) send_item(CMD_TICK, 16'h0000, OP_CREATE, 1'b0);
      calm = 1'b0;
      run_traffic(3);

      write_timeout(8'd1);
      run_traffic(3);

      settle();
      if (board.failures == 0 && board.pending() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule
